// ===== rtl/dda_line_rasterizer_macros.svh =====
// Assertion macros for the port-level checker of the line rasterizer.
// Each use expands to one labeled concurrent assertion, sampled on the
// rising clock edge and disabled while the active-low reset is asserted.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define DDA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("dda assertion failed");

// Next-cycle implication.
`define DDA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("dda assertion failed");

`endif

// ===== rtl/dda_pkg.sv =====
`timescale 1ns / 1ps

package dda_pkg;

    localparam int SCREEN_SIDE = 64;
    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 32;
    localparam int REM_W       = COORD_W + 1;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(SCREEN_SIDE - 1);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } dda_state_t;

    // Control from the sequencer to each axis stepper.
    typedef struct packed {
        logic load;
        logic step;
    } dda_axis_ctl_t;

    // Coordinates at or beyond the screen edge are pulled back onto it.
    function automatic coord_t clamp_coord(input coord_t c);
        coord_t r;
        r = c;
        if (c > COORD_MAX)
        begin
            r = COORD_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/dda_cmd_if.sv =====
`timescale 1ns / 1ps

interface dda_cmd_if;
    logic            valid;
    logic            ready;
    dda_pkg::coord_t start_x;
    dda_pkg::coord_t start_y;
    dda_pkg::coord_t end_x;
    dda_pkg::coord_t end_y;
    dda_pkg::color_t line_color;

    modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

// ===== rtl/dda_pix_if.sv =====
`timescale 1ns / 1ps

interface dda_pix_if;
    logic            valid;
    logic            ready;
    dda_pkg::coord_t pixel_x;
    dda_pkg::coord_t pixel_y;
    dda_pkg::color_t pixel_color;
    logic            last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== rtl/dda_axis.sv =====
`timescale 1ns / 1ps

// One coordinate axis: holds start and end and steps k*mag/len exactly
// as a quotient and a remainder, one add and compare per step.
module dda_axis (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dda_pkg::dda_axis_ctl_t ctl,
    input  dda_pkg::coord_t        pos_start,
    input  dda_pkg::coord_t        pos_end,
    input  dda_pkg::coord_t        len,
    output dda_pkg::coord_t        mag,
    output dda_pkg::coord_t        coord
);

    dda_pkg::coord_t s_reg, s_next;
    dda_pkg::coord_t e_reg, e_next;
    dda_pkg::coord_t q_reg, q_next;
    dda_pkg::coord_t r_reg, r_next;

    logic                      up;
    logic [dda_pkg::REM_W-1:0] r_sum;

    assign up  = (e_reg >= s_reg);
    assign mag = up ? (e_reg - s_reg) : (s_reg - e_reg);

    // Falling direction rounds the offset up, so the coordinate rounds down.
    assign coord = up ? (s_reg + q_reg)
                      : (s_reg - q_reg - dda_pkg::coord_t'(r_reg != '0));

    always_comb
    begin
        s_next = s_reg;
        e_next = e_reg;
        q_next = q_reg;
        r_next = r_reg;
        r_sum  = {1'b0, r_reg} + {1'b0, mag};
        if (ctl.load)
        begin
            s_next = dda_pkg::clamp_coord(pos_start);
            e_next = dda_pkg::clamp_coord(pos_end);
            q_next = '0;
            r_next = '0;
        end
        else if (ctl.step)
        begin
            if (r_sum >= {1'b0, len})
            begin
                r_next = dda_pkg::coord_t'(r_sum - {1'b0, len});
                q_next = q_reg + 1'b1;
            end
            else
            begin
                r_next = r_sum[dda_pkg::COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        e_reg <= e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
            r_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

endmodule

// ===== rtl/dda_seq.sv =====
`timescale 1ns / 1ps

// Sequencer: takes a command, sets the line length, then steps both axes
// once per pixel that the output register can take.
module dda_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  dda_pkg::coord_t        mag_x,
    input  dda_pkg::coord_t        mag_y,
    input  logic                   out_free,
    output dda_pkg::dda_axis_ctl_t ctl,
    output dda_pkg::coord_t        len,
    output logic                   emit,
    output logic                   last
);

    dda_pkg::dda_state_t state_reg, state_next;
    dda_pkg::coord_t     len_reg, len_next;
    dda_pkg::coord_t     k_reg, k_next;

    assign len  = len_reg;
    assign last = (k_reg == len_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        cmd_ready  = 1'b0;
        emit       = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            dda_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = dda_pkg::ST_SETUP;
                end
            end
            dda_pkg::ST_SETUP:
            begin
                len_next = (mag_x > mag_y) ? mag_x : mag_y;
                k_next   = '0;
                // A zero-length line produces no pixels.
                if (len_next == '0)
                begin
                    state_next = dda_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = dda_pkg::ST_RUN;
                end
            end
            dda_pkg::ST_RUN:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    ctl.step = 1'b1;
                    k_next   = k_reg + 1'b1;
                    if (last)
                    begin
                        state_next = dda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_pkg::ST_IDLE;
            len_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== rtl/dda_line_rasterizer.sv =====
`timescale 1ns / 1ps

// Channel  Role    Beat contents
// -------  ------  ----------------------------------------------------
// cmd      sink    start_x, start_y, end_x, end_y, line_color
// pix      source  pixel_x, pixel_y, pixel_color, last_pixel
//
// A line of length L (the larger of the two coordinate spans) is handled in
// steps: the command beat is accepted, L is computed, then pixels go one
// per cycle, unless pix stalls, from the two axis steppers to the output register.
// The next command is taken as soon as the last pixel has entered the
// output register. A zero-length line emits nothing, going idle from set-up.
// Reset is asynchronous and active low; it idles the sequencer and empties
// the output register. A stall on pix holds the pixel and pauses stepping.
module dda_line_rasterizer (
    input  logic      clk,
    input  logic      rst_n,
    dda_cmd_if.sink   cmd,
    dda_pix_if.source pix
);

    dda_pkg::dda_axis_ctl_t ctl;
    dda_pkg::coord_t        len;
    dda_pkg::coord_t        mag_x;
    dda_pkg::coord_t        mag_y;
    dda_pkg::coord_t        coord_x;
    dda_pkg::coord_t        coord_y;
    logic                   emit;
    logic                   last;
    logic                   out_free;

    // The color word is held for the whole line.
    dda_pkg::color_t color_reg, color_next;

    // Output register: one pixel beat waiting for the consumer.
    logic            pix_valid_reg, pix_valid_next;
    dda_pkg::coord_t pix_x_reg, pix_x_next;
    dda_pkg::coord_t pix_y_reg, pix_y_next;
    dda_pkg::color_t pix_color_reg, pix_color_next;
    logic            pix_last_reg, pix_last_next;

    assign out_free = !pix_valid_reg || pix.ready;

    dda_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .out_free  (out_free),
        .ctl       (ctl),
        .len       (len),
        .emit      (emit),
        .last      (last)
    );

    dda_axis u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .pos_start (cmd.start_x),
        .pos_end   (cmd.end_x),
        .len       (len),
        .mag       (mag_x),
        .coord     (coord_x)
    );

    dda_axis u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .pos_start (cmd.start_y),
        .pos_end   (cmd.end_y),
        .len       (len),
        .mag       (mag_y),
        .coord     (coord_y)
    );

    always_comb
    begin
        color_next     = ctl.load ? cmd.line_color : color_reg;
        pix_valid_next = pix_valid_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        pix_color_next = pix_color_reg;
        pix_last_next  = pix_last_reg;
        if (emit)
        begin
            // The stepper's current coordinates belong to this pixel; the
            // step taken in the same cycle prepares the next one.
            pix_valid_next = 1'b1;
            pix_x_next     = coord_x;
            pix_y_next     = coord_y;
            pix_color_next = color_reg;
            pix_last_next  = last;
        end
        else if (pix.ready)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        pix_color_reg <= pix_color_next;
        pix_last_reg  <= pix_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    assign pix.valid       = pix_valid_reg;
    assign pix.pixel_x     = pix_x_reg;
    assign pix.pixel_y     = pix_y_reg;
    assign pix.pixel_color = pix_color_reg;
    assign pix.last_pixel  = pix_last_reg;

endmodule

// ===== rtl/dda_chk.sv =====
`timescale 1ns / 1ps
`include "dda_line_rasterizer_macros.svh"

// Port-level checks for the line rasterizer.
module dda_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_ready,
    input logic            pix_valid,
    input logic            pix_ready,
    input dda_pkg::coord_t pixel_x,
    input dda_pkg::coord_t pixel_y,
    input dda_pkg::color_t pixel_color,
    input logic            last_pixel
);

    // A stalled pixel beat stays and keeps its contents.
    `DDA_ASSERT_NXT(a_pix_hold, clk, rst_n, pix_valid && !pix_ready, pix_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) && $stable(last_pixel))

    // A taken command keeps the block busy for at least the set-up cycle.
    `DDA_ASSERT_NXT(a_busy_after_cmd, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // No new command is taken while a line is still being drawn.
    `DDA_ASSERT_IMP(a_busy_mid_line, clk, rst_n, pix_valid && !last_pixel, !cmd_ready)

endmodule

bind dda_line_rasterizer dda_chk u_dda_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .pix_valid   (pix.valid),
    .pix_ready   (pix.ready),
    .pixel_x     (pix.pixel_x),
    .pixel_y     (pix.pixel_y),
    .pixel_color (pix.pixel_color),
    .last_pixel  (pix.last_pixel)
);

// ===== dv/dda_line_checker.sv =====
`timescale 1ns / 1ps

module dda_line_checker (
    input  logic clk,
    input  logic rst_n,
    dda_cmd_if   cmd,
    dda_pix_if   pix,
    output int   mismatches,
    output int   pixels_owed
);
    import dda_pkg::*;

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    pixel_t pixels_due[$];
    int     bad_beats;

    // Coordinate on one axis after k of len steps, rounded toward minus infinity.
    function automatic coord_t axis_at(input coord_t origin, input coord_t target,
                                       input int k, input int len);
        int o;
        int t;
        o = int'(origin);
        t = int'(target);
        if (t >= o)
        begin
            return coord_t'(o + (k * (t - o)) / len);
        end
        return coord_t'(o - (k * (o - t) + len - 1) / len);
    endfunction

    // Queues every pixel that one line command must produce, in drawing order.
    function automatic void rasterize_line(input coord_t sx, input coord_t sy,
                                           input coord_t ex, input coord_t ey,
                                           input color_t c);
        int     dx;
        int     dy;
        int     len;
        pixel_t p;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0)
        begin
            dx = -dx;
        end
        if (dy < 0)
        begin
            dy = -dy;
        end
        len = (dx > dy) ? dx : dy;
        for (int k = 0; k < len; k++)
        begin
            p.x     = axis_at(sx, ex, k, len);
            p.y     = axis_at(sy, ey, k, len);
            p.color = c;
            p.last  = (k + 1 == len);
            pixels_due.push_back(p);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        if (!rst_n)
        begin
            pixels_due.delete();
            bad_beats = 0;
            mismatches  <= 0;
            pixels_owed <= 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    if (bad_beats < 10)
                    begin
                        $display("unexpected pixel beat: x=%0d y=%0d color=%08h last=%0b",
                                 pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last_pixel);
                    end
                    bad_beats++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (pix.pixel_x !== want.x || pix.pixel_y !== want.y ||
                        pix.pixel_color !== want.color || pix.last_pixel !== want.last)
                    begin
                        if (bad_beats < 10)
                        begin
                            $display("pixel mismatch: expected x=%0d y=%0d color=%08h last=%0b",
                                     want.x, want.y, want.color, want.last);
                            $display("                got      x=%0d y=%0d color=%08h last=%0b",
                                     pix.pixel_x, pix.pixel_y, pix.pixel_color,
                                     pix.last_pixel);
                        end
                        bad_beats++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                rasterize_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y, cmd.line_color);
            end
            mismatches  <= bad_beats;
            pixels_owed <= pixels_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dda_pkg::*;

    // Worst case is roughly 380 lines of 63 pixels, each pixel held up by the
    // longest sink stall, plus sender gaps; the limit leaves a wide margin on that.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_LINES = 360;
    // The last stretch of random lines runs with both sides flat out.
    localparam int CALM_LINES   = 40;

    logic clk;
    logic rst_n;
    logic calm;
    int   cycle_count;
    int   mismatches;
    int   pixels_owed;

    dda_cmd_if cmd_bus ();
    dda_pix_if pix_bus ();

    dda_line_rasterizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus)
    );

    // The checker watches both channels, predicts every pixel beat from the
    // accepted commands and compares what the block sends.
    dda_line_checker line_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_bus),
        .pix         (pix_bus),
        .mismatches  (mismatches),
        .pixels_owed (pixels_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is bounded no matter what the block does with its handshakes.
    // The counter is a two-state int, so it starts from zero.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Pulls a coordinate a few steps away from c, kept on screen, so that
    // short lines of length zero to four show up often.
    function automatic coord_t nearby(input coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > SCREEN_SIDE - 1)
        begin
            v = SCREEN_SIDE - 1;
        end
        return coord_t'(v);
    endfunction

    // Presents one command beat and returns at the edge where it is taken.
    // Before the beat the sender may go quiet for a burst of cycles; valid is
    // only lowered when such a gap follows, so back-to-back beats keep it high.
    task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey, input color_t c);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.start_x    <= sx;
        cmd_bus.start_y    <= sy;
        cmd_bus.end_x      <= ex;
        cmd_bus.end_y      <= ey;
        cmd_bus.line_color <= c;
        @(posedge clk);
        while (!cmd_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    // The pixel sink alternates stretches of readiness with random stall bursts,
    // so that stalls land on every pixel position of a line, including the
    // first and the last. Once the run turns calm it never stalls.
    initial
    begin
        pix_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (calm)
            begin
                pix_bus.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                pix_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                pix_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int     mode;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;

        calm               = 1'b0;
        rst_n              <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.start_x    <= '0;
        cmd_bus.start_y    <= '0;
        cmd_bus.end_x      <= '0;
        cmd_bus.end_y      <= '0;
        cmd_bus.line_color <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines. Zero-length commands must produce no pixels at all,
        // including two in a row and one at the far corner of the screen.
        send_line(6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);
        // Full-width and full-height lines in both directions: the longest
        // lines the screen allows, 63 pixels each.
        send_line(6'd0,  6'd0,  6'd63, 6'd0,  32'hFFFF_FFFF);
        send_line(6'd63, 6'd0,  6'd0,  6'd0,  32'h0000_0000);
        send_line(6'd0,  6'd0,  6'd0,  6'd63, 32'hA5A5_A5A5);
        send_line(6'd0,  6'd63, 6'd0,  6'd0,  32'h5A5A_5A5A);
        // Both diagonals, each way round.
        send_line(6'd0,  6'd0,  6'd63, 6'd63, 32'h1234_5678);
        send_line(6'd63, 6'd63, 6'd0,  6'd0,  32'h8765_4321);
        send_line(6'd0,  6'd63, 6'd63, 6'd0,  32'hDEAD_BEEF);
        send_line(6'd63, 6'd0,  6'd0,  6'd63, 32'h2152_4110);
        // Very shallow and very steep lines, where the minor axis spans one step;
        // the negative direction rounds toward minus infinity.
        send_line(6'd0,  6'd0,  6'd63, 6'd1,  32'h0F0F_0F0F);
        send_line(6'd1,  6'd0,  6'd0,  6'd63, 32'hF0F0_F0F0);
        // Single-pixel lines: the one pixel is also the last.
        send_line(6'd10, 6'd20, 6'd11, 6'd20, 32'h8000_0001);
        send_line(6'd10, 6'd20, 6'd10, 6'd19, 32'h7FFF_FFFE);
        send_line(6'd0,  6'd0,  6'd1,  6'd1,  32'h0000_0001);
        // General slopes with both axes decreasing or mixed, then one zero-length line.
        send_line(6'd5,  6'd40, 6'd50, 6'd2,  32'hCAFE_F00D);
        send_line(6'd62, 6'd1,  6'd3,  6'd7,  32'h3C3C_C3C3);
        send_line(6'd21, 6'd42, 6'd42, 6'd21, 32'h0123_4567);
        send_line(6'd32, 6'd32, 6'd0,  6'd31, 32'h89AB_CDEF);
        send_line(6'd7,  6'd7,  6'd7,  6'd7,  32'h8000_0001);

        // Random lines: a mix of zero-length commands, short lines whose ends
        // sit a few steps from the start, and lines across the whole screen.
        for (int n = 0; n < RANDOM_LINES; n++)
        begin
            if (n == RANDOM_LINES - CALM_LINES)
            begin
                calm = 1'b1;
            end
            mode = $urandom_range(0, 9);
            sx   = coord_t'($urandom_range(0, SCREEN_SIDE - 1));
            sy   = coord_t'($urandom_range(0, SCREEN_SIDE - 1));
            if (mode == 0)
            begin
                ex = sx;
                ey = sy;
            end
            else if (mode <= 3)
            begin
                ex = nearby(sx);
                ey = nearby(sy);
            end
            else
            begin
                ex = coord_t'($urandom_range(0, SCREEN_SIDE - 1));
                ey = coord_t'($urandom_range(0, SCREEN_SIDE - 1));
            end
            send_line(sx, sy, ex, ey, color_t'($urandom));
        end
        cmd_bus.valid <= 1'b0;

        // Drain: wait for every predicted pixel, then give the block a few
        // more cycles, long enough for a trailing zero-length line to settle
        // and for any stray beat to show up at the checker.
        @(posedge clk);
        while (pixels_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pixels_owed == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
